// ----- rtl/wvg_pkg.sv -----
// shared types and constants for the waypoint velocity guidance block
`default_nettype none
package wvg_pkg;
    localparam int MaxWaypoints = 64;
    localparam int IdxW = $clog2(MaxWaypoints);
    localparam int CntW = $clog2(MaxWaypoints + 1);

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_POS  = 1'b1;

    localparam logic [0:0] REG_GAIN = 1'b0;
    localparam logic [0:0] REG_TOL  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_DIFF,
        ST_SQ,
        ST_ARR,
        ST_PREP,
        ST_SQRT,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic pos_item;
        logic read_wp;
        logic diff;
        logic square;
        logic arr_check;
        logic prep;
        logic sqrt_step;
        logic div_step;
        logic out_load;
        logic adv_index;
    } cmd_t;

    typedef struct packed {
        logic arrived;
        logic done_now;
        logic done_next;
        logic sqrt_last;
        logic div_last;
        logic dist_zero;
    } stat_t;
endpackage
`default_nettype wire

// ----- rtl/wvg_if.sv -----
// valid/ready channel interfaces for input items and results
`default_nettype none
interface wvg_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic               first_point;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    modport source (output valid, func, first_point, coord_x, coord_y, input ready);
    modport sink (input valid, func, first_point, coord_x, coord_y, output ready);
endinterface

interface wvg_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] vel_x;
    logic signed [16:0] vel_y;
    logic               finished;
    logic [6:0]         target_index;
    logic               overflow;
    modport source (output valid, vel_x, vel_y, finished, target_index, overflow,
                    input ready);
    modport sink (input valid, vel_x, vel_y, finished, target_index, overflow,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/wvg_ctrl.sv -----
// controller state machine sequencing loads, arrival test, sqrt and divide
`default_nettype none
module wvg_ctrl
    import wvg_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire logic  in_func,
    output logic       in_ready,
    input  wire logic  out_ready,
    output logic       out_valid,
    input  wire stat_t stat,
    output cmd_t       cmd
);
    state_t state_reg, state_next;
    logic   second_reg, second_next;
    logic   ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            second_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
            ov_reg     <= ov_next;
        end
    end

    assign out_valid = ov_reg;

    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        ov_next     = ov_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_func == FUNC_LOAD)
                        cmd.load_item = 1'b1;
                    else
                    begin
                        cmd.pos_item = 1'b1;
                        second_next  = 1'b0;
                        state_next   = ST_RD;
                    end
                end
            end
            ST_RD:
            begin
                if (stat.done_now)
                    state_next = ST_OUT;
                else
                begin
                    cmd.read_wp = 1'b1;
                    state_next  = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = second_reg ? ST_PREP : ST_SQ;
            end
            ST_SQ:
            begin
                cmd.square = 1'b1;
                state_next = ST_ARR;
            end
            ST_ARR:
            begin
                cmd.arr_check = 1'b1;
                if (stat.arrived)
                begin
                    cmd.adv_index = 1'b1;
                    second_next   = 1'b1;
                    if (stat.done_next)
                        state_next = ST_OUT;
                    else
                        state_next = ST_RD;
                end
                else
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (stat.sqrt_last)
                    state_next = ST_DIV;
                else
                    state_next = ST_SQRT;
            end
            ST_DIV:
            begin
                if (stat.dist_zero)
                    state_next = ST_OUT;
                else
                begin
                    cmd.div_step = 1'b1;
                    if (stat.div_last)
                        state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/wvg_dp.sv -----
// datapath: waypoint memory, arrival test, bit-serial sqrt and divide
`default_nettype none
module wvg_dp
    import wvg_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output stat_t                   stat,
    input  wire logic               first_point,
    input  wire logic signed [31:0] coord_x,
    input  wire logic signed [31:0] coord_y,
    input  wire logic [15:0]        gain,
    input  wire logic [30:0]        tol,
    output logic signed [16:0]      vel_x,
    output logic signed [16:0]      vel_y,
    output logic                    finished,
    output logic [6:0]              target_index,
    output logic                    overflow
);
    logic [63:0] mem [MaxWaypoints];
    logic [63:0] rd_reg;
    logic [CntW-1:0] count_reg, idx_reg;
    logic ovf_reg;
    logic signed [31:0] px_reg, py_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic [31:0] ax_reg, ay_reg;
    logic [62:0] sqx_reg, sqy_reg;
    logic [63:0] rem_reg, root_reg;
    logic [5:0]  sstep_reg;
    logic [31:0] d_reg;
    logic [47:0] nx_reg, ny_reg;
    logic [32:0] rx_reg, ry_reg;
    logic [5:0]  dstep_reg;
    logic [16:0] qx_reg, qy_reg;
    logic signed [16:0] vx_reg, vy_reg;
    logic fin_reg;
    logic [6:0] tix_reg;
    logic ovo_reg;

    logic [CntW-1:0] slot;
    logic            full;
    logic [32:0]     mx, my;
    logic            big;
    logic [63:0]     trial, rem_n, root_n;
    logic [32:0]     tx, ty;
    logic [61:0]     tolsq;
    logic [63:0]     sqsum;

    assign slot = first_point ? '0 : count_reg;
    assign full = slot >= CntW'(MaxWaypoints);
    assign mx   = dx_reg[32] ? -dx_reg : dx_reg;
    assign my   = dy_reg[32] ? -dy_reg : dy_reg;
    assign big  = mx[32] | my[32] | mx[31] | my[31];
    assign tolsq = {31'd0, tol} * {31'd0, tol};
    assign sqsum = 64'(sqx_reg) + 64'(sqy_reg);

    // one restoring sqrt step: two bits of the radicand per cycle
    always_comb
    begin
        trial  = root_reg | (64'd1 << {sstep_reg[4:0], 1'b0});
        rem_n  = rem_reg;
        root_n = root_reg >> 1;
        if (rem_reg >= trial)
        begin
            rem_n  = rem_reg - trial;
            root_n = (root_reg >> 1) | (64'd1 << {sstep_reg[4:0], 1'b0});
        end
    end

    assign tx = {rx_reg[31:0], nx_reg[47]};
    assign ty = {ry_reg[31:0], ny_reg[47]};

    always_ff @(posedge clk)
    begin
        if (cmd.load_item && !full)
            mem[slot[IdxW-1:0]] <= {coord_x, coord_y};
        if (cmd.read_wp)
            rd_reg <= mem[idx_reg[IdxW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                if (full)
                    ovf_reg <= 1'b1;
                else
                    count_reg <= slot + 1'b1;
                if (first_point)
                    idx_reg <= '0;
            end
            if (cmd.adv_index)
                idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pos_item)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        if (cmd.diff)
        begin
            dx_reg <= 33'(signed'(rd_reg[63:32])) - 33'(px_reg);
            dy_reg <= 33'(signed'(rd_reg[31:0])) - 33'(py_reg);
        end
        if (cmd.square)
        begin
            sqx_reg <= {31'd0, mx[31:0]} * {31'd0, mx[31:0]};
            sqy_reg <= {31'd0, my[31:0]} * {31'd0, my[31:0]};
        end
        if (cmd.prep)
        begin
            ax_reg <= big ? mx[32:1] : mx[31:0];
            ay_reg <= big ? my[32:1] : my[31:0];
            sstep_reg <= 6'd33;
            root_reg  <= '0;
        end
        if (cmd.sqrt_step)
        begin
            // step 33 squares, step 32 sums, 31 down to 0 are bit pairs
            if (sstep_reg == 6'd33)
            begin
                sqx_reg <= {31'd0, ax_reg} * {31'd0, ax_reg};
                sqy_reg <= {31'd0, ay_reg} * {31'd0, ay_reg};
                sstep_reg <= 6'd32;
            end
            else if (sstep_reg == 6'd32)
            begin
                rem_reg   <= sqsum;
                sstep_reg <= 6'd31;
            end
            else
            begin
                rem_reg   <= rem_n;
                root_reg  <= root_n;
                sstep_reg <= sstep_reg - 1'b1;
            end
        end
        if (stat.sqrt_last && cmd.sqrt_step)
        begin
            d_reg     <= root_n[31:0];
            nx_reg    <= {16'd0, ax_reg} * {32'd0, gain};
            ny_reg    <= {16'd0, ay_reg} * {32'd0, gain};
            rx_reg    <= '0;
            ry_reg    <= '0;
            dstep_reg <= '0;
        end
        if (cmd.div_step)
        begin
            // restoring division, one quotient bit per cycle, both axes
            if (tx >= {1'b0, d_reg})
            begin
                rx_reg <= tx - {1'b0, d_reg};
                nx_reg <= {nx_reg[46:0], 1'b1};
            end
            else
            begin
                rx_reg <= tx;
                nx_reg <= {nx_reg[46:0], 1'b0};
            end
            if (ty >= {1'b0, d_reg})
            begin
                ry_reg <= ty - {1'b0, d_reg};
                ny_reg <= {ny_reg[46:0], 1'b1};
            end
            else
            begin
                ry_reg <= ty;
                ny_reg <= {ny_reg[46:0], 1'b0};
            end
            dstep_reg <= dstep_reg + 1'b1;
        end
        if (cmd.read_wp)
        begin
            qx_reg <= '0;
            qy_reg <= '0;
        end
        if (cmd.div_step && stat.div_last)
        begin
            qx_reg <= {nx_reg[15:0], tx >= {1'b0, d_reg}};
            qy_reg <= {ny_reg[15:0], ty >= {1'b0, d_reg}};
        end
        if (cmd.out_load)
        begin
            fin_reg <= stat.done_now;
            tix_reg <= 7'(idx_reg);
            ovo_reg <= ovf_reg;
            if (stat.done_now)
            begin
                vx_reg <= '0;
                vy_reg <= '0;
            end
            else
            begin
                vx_reg <= dx_reg[32] ? -qx_reg : qx_reg;
                vy_reg <= dy_reg[32] ? -qy_reg : qy_reg;
            end
        end
    end

    // last of the 32 bit-pair steps of the sqrt
    assign stat.sqrt_last = cmd.sqrt_step && sstep_reg == 6'd0;
    assign stat.arrived   = cmd.arr_check && !big && (sqsum < 64'(tolsq));
    assign stat.done_now  = idx_reg >= count_reg;
    assign stat.done_next = (idx_reg + 1'b1) >= count_reg;
    assign stat.div_last  = dstep_reg == 6'd47;
    assign stat.dist_zero = d_reg == '0;

    assign vel_x        = vx_reg;
    assign vel_y        = vy_reg;
    assign finished     = fin_reg;
    assign target_index = tix_reg;
    assign overflow     = ovo_reg;
endmodule
`default_nettype wire

// ----- rtl/waypoint_velocity_guidance.sv -----
// waypoint velocity guidance: a load is stored while idle; a position update
// reads the waypoint, runs the arrival test, a restoring sqrt (setup steps,
// then bit pairs), a restoring divide and the output load; an arrival advances
// the target, zero distance skips the divide, a done list goes to the output
// one item in flight at a time; results wait in an output register
// rst_n asynchronous: empties the list, clears index and overflow, gain 1.0,
// tolerance 1.0; waypoint memory is not cleared
`default_nettype none
module waypoint_velocity_guidance
    import wvg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    wvg_in_if.sink           in_ch,
    wvg_out_if.source        out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:2]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    cmd_t  cmd;
    stat_t stat;
    logic [15:0] gain_reg;
    logic [30:0] tol_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= 16'd256;
            tol_reg  <= 31'd65536;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[2])
                REG_GAIN: gain_reg <= pwdata[15:0];
                REG_TOL:  tol_reg  <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_GAIN: prdata = {16'd0, gain_reg};
            REG_TOL:  prdata = {1'b0, tol_reg};
            default:  prdata = '0;
        endcase
    end

    wvg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_func   (in_ch.func),
        .in_ready  (in_ch.ready),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    wvg_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .first_point  (in_ch.first_point),
        .coord_x      (in_ch.coord_x),
        .coord_y      (in_ch.coord_y),
        .gain         (gain_reg),
        .tol          (tol_reg),
        .vel_x        (out_ch.vel_x),
        .vel_y        (out_ch.vel_y),
        .finished     (out_ch.finished),
        .target_index (out_ch.target_index),
        .overflow     (out_ch.overflow)
    );
endmodule
`default_nettype wire
